[hw/rtl/icda_pkg.sv]
`default_nettype none
package icda_pkg;

  // Output channels computed; lanes past the four weight words get no inputs
  localparam int unsigned LANES     = 4;
  localparam int unsigned IO_LANES  = 4;
  localparam int unsigned ACT_LANES = (LANES < IO_LANES) ? LANES : IO_LANES;

  localparam int unsigned SRC_BYTES = 4;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned PAIR_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERFLOW_MODE = 2'd0,
    CFG_ZERO_POINT    = 2'd1
  } cfg_reg_e;

  typedef logic [SRC_BYTES-1:0][7:0] src_t;
  typedef logic [SRC_BYTES-1:0][7:0] wgt_t;

  // Stage flags kept by the front end
  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
    logic s2_start;
    logic s2_last;
  } pipe_flags_t;

  // Control seen by every lane
  typedef struct packed {
    logic adv;
    logic ovf;
    logic s1_valid;
    logic s2_valid;
    logic s2_start;
  } lane_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/icda_if.sv]
`default_nettype none
interface icda_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_bytes;
  logic [31:0] weights_lane0;
  logic [31:0] weights_lane1;
  logic [31:0] weights_lane2;
  logic [31:0] weights_lane3;
  logic [2:0]  valid_bytes;
  logic        pad;
  logic        start_req;
  logic        last;

  modport source (
    output valid, src_bytes, weights_lane0, weights_lane1, weights_lane2, weights_lane3,
           valid_bytes, pad, start_req, last,
    input  ready
  );
  modport sink (
    input  valid, src_bytes, weights_lane0, weights_lane1, weights_lane2, weights_lane3,
           valid_bytes, pad, start_req, last,
    output ready
  );
endinterface

interface icda_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sum_lane0;
  logic signed [31:0] sum_lane1;
  logic signed [31:0] sum_lane2;
  logic signed [31:0] sum_lane3;

  modport source (
    output valid, sum_lane0, sum_lane1, sum_lane2, sum_lane3,
    input  ready
  );
  modport sink (
    input  valid, sum_lane0, sum_lane1, sum_lane2, sum_lane3,
    output ready
  );
endinterface
`default_nettype wire

[hw/rtl/icda_front.sv]
`default_nettype none
module icda_front (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        adv_i,
  input  wire                        acc_i,
  input  wire  [31:0]                src_bytes_i,
  input  wire  [2:0]                 valid_bytes_i,
  input  wire                        pad_i,
  input  wire                        start_i,
  input  wire                        last_i,
  input  wire  [7:0]                 zero_point_i,
  input  wire  icda_pkg::wgt_t [icda_pkg::IO_LANES-1:0] wgt_i,
  output icda_pkg::src_t             src_o,
  output icda_pkg::wgt_t [icda_pkg::IO_LANES-1:0] wgt_o,
  output icda_pkg::pipe_flags_t      flags_o
);
  import icda_pkg::*;

  src_t        src_d, src_q;
  wgt_t [IO_LANES-1:0] wgt_q;
  logic        s1_valid_q, s1_start_q, s1_last_q;
  logic        s2_valid_q, s2_start_q, s2_last_q;

  // Pad takes the zero point everywhere; otherwise zero the tail bytes
  always_comb begin
    for (int i = 0; i < SRC_BYTES; i++) begin
      if (pad_i) begin
        src_d[i] = zero_point_i;
      end else if (3'(i) < valid_bytes_i) begin
        src_d[i] = src_bytes_i[8*i +: 8];
      end else begin
        src_d[i] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && acc_i) begin
      src_q <= src_d;
      wgt_q <= wgt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_start_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_start_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= acc_i;
      s1_start_q <= acc_i && start_i;
      s1_last_q  <= acc_i && last_i;
      s2_valid_q <= s1_valid_q;
      s2_start_q <= s1_start_q;
      s2_last_q  <= s1_last_q;
    end
  end

  assign src_o            = src_q;
  assign wgt_o            = wgt_q;
  assign flags_o.s1_valid = s1_valid_q;
  assign flags_o.s2_valid = s2_valid_q;
  assign flags_o.s2_start = s2_start_q;
  assign flags_o.s2_last  = s2_last_q;

endmodule
`default_nettype wire

[hw/rtl/icda_lane.sv]
`default_nettype none
module icda_lane (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire  icda_pkg::lane_ctl_t ctl_i,
  input  wire  icda_pkg::src_t      src_i,
  input  wire  icda_pkg::wgt_t      wgt_i,
  output logic signed [icda_pkg::ACC_W-1:0] acc_next_o
);
  import icda_pkg::*;

  function automatic logic signed [PAIR_W-1:0] pair_sum(
    input logic [7:0] a0, input logic [7:0] w0,
    input logic [7:0] a1, input logic [7:0] w1,
    input logic       sat
  );
    logic signed [16:0] p0, p1;
    logic signed [17:0] s;
    logic signed [PAIR_W-1:0] r;
    p0 = $signed({1'b0, a0}) * $signed(w0);
    p1 = $signed({1'b0, a1}) * $signed(w1);
    s  = 18'(p0) + 18'(p1);
    if (sat && s > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (sat && s < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = s[PAIR_W-1:0];
    end
    return r;
  endfunction

  logic signed [PAIR_W-1:0] p0_d, p1_d;
  logic signed [PAIR_W:0]   ps_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_base;

  assign p0_d = pair_sum(src_i[0], wgt_i[0], src_i[1], wgt_i[1], ctl_i.ovf);
  assign p1_d = pair_sum(src_i[2], wgt_i[2], src_i[3], wgt_i[3], ctl_i.ovf);

  // Both pair sums fit one 17-bit word; register before the accumulator add
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.s1_valid) begin
      ps_q <= (PAIR_W+1)'(p0_d) + (PAIR_W+1)'(p1_d);
    end
  end

  assign acc_base   = ctl_i.s2_start ? '0 : acc_q;
  assign acc_next_o = acc_base + ACC_W'(ps_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.adv && ctl_i.s2_valid) begin
      acc_q <= acc_next_o;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/icda_merge.sv]
`default_nettype none
module icda_merge (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire  icda_pkg::pipe_flags_t flags_i,
  input  wire  signed [icda_pkg::ACC_W-1:0] acc_next_i [icda_pkg::ACT_LANES],
  output logic                      adv_o,
  icda_out_if.source                res_o
);
  import icda_pkg::*;

  logic                      valid_q;
  logic signed [ACC_W-1:0]   sum_q [IO_LANES];

  // Whole pipe moves unless a finished beat waits unclaimed
  assign adv_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= flags_i.s2_valid && flags_i.s2_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && flags_i.s2_valid && flags_i.s2_last) begin
      for (int k = 0; k < IO_LANES; k++) begin
        sum_q[k] <= (k < ACT_LANES) ? acc_next_i[k] : '0;
      end
    end
  end

  assign res_o.valid     = valid_q;
  assign res_o.sum_lane0 = sum_q[0];
  assign res_o.sum_lane1 = sum_q[1];
  assign res_o.sum_lane2 = sum_q[2];
  assign res_o.sum_lane3 = sum_q[3];

endmodule
`default_nettype wire

[hw/rtl/int8_conv_dot_accumulator.sv]
`default_nettype none
// Channel  Dir  Beat carries
// src_i    in   source bytes, four weight words, valid count, pad, start, last
// res_o    out  four 32-bit lane sums, one beat per item flagged last
// cfg      in   overflow_mode (index 0), zero_point (index 1), write only
//
// One item per cycle while results are claimed; from accept to result valid an item passes
// byte select, pair-sum register, then accumulate into the output register.
// Reset clears the accumulators, the configuration and all stage flags.
// A result left unclaimed stalls every stage and drops ready on src_i.
module int8_conv_dot_accumulator (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [icda_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [icda_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  icda_in_if.sink                          src_i,
  icda_out_if.source                       res_o
);
  import icda_pkg::*;

  logic        ovf_q;
  logic [7:0]  zp_q;
  logic        adv;
  logic        acc;
  wgt_t [IO_LANES-1:0] wgt_in, wgt_s1;
  src_t        src_s1;
  pipe_flags_t flags;
  lane_ctl_t   lane_ctl;
  logic signed [ACC_W-1:0] acc_next [ACT_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
      zp_q  <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_OVERFLOW_MODE: ovf_q <= cfg_wdata_i[0];
        CFG_ZERO_POINT:    zp_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign src_i.ready = adv;
  assign acc         = src_i.valid && adv;
  assign wgt_in[0]   = src_i.weights_lane0;
  assign wgt_in[1]   = src_i.weights_lane1;
  assign wgt_in[2]   = src_i.weights_lane2;
  assign wgt_in[3]   = src_i.weights_lane3;

  icda_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .acc_i        (acc),
    .src_bytes_i  (src_i.src_bytes),
    .valid_bytes_i(src_i.valid_bytes),
    .pad_i        (src_i.pad),
    .start_i      (src_i.start_req),
    .last_i       (src_i.last),
    .zero_point_i (zp_q),
    .wgt_i        (wgt_in),
    .src_o        (src_s1),
    .wgt_o        (wgt_s1),
    .flags_o      (flags)
  );

  assign lane_ctl.adv      = adv;
  assign lane_ctl.ovf      = ovf_q;
  assign lane_ctl.s1_valid = flags.s1_valid;
  assign lane_ctl.s2_valid = flags.s2_valid;
  assign lane_ctl.s2_start = flags.s2_start;

  for (genvar k = 0; k < ACT_LANES; k++) begin : g_lane
    icda_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (lane_ctl),
      .src_i     (src_s1),
      .wgt_i     (wgt_s1[k]),
      .acc_next_o(acc_next[k])
    );
  end

  icda_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .flags_i   (flags),
    .acc_next_i(acc_next),
    .adv_o     (adv),
    .res_o     (res_o)
  );

  a_res_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(flags.s2_valid && flags.s2_last))
    else $error("result raised without a last item in the accumulate stage");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> ($stable(flags) && $stable(res_o.sum_lane0)))
    else $error("pipeline moved while the result was stalled");

  a_pad_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && src_i.pad) |=> (src_s1[0] == $past(zp_q) && src_s1[1] == $past(zp_q) &&
                            src_s1[2] == $past(zp_q) && src_s1[3] == $past(zp_q)))
    else $error("pad item did not take the zero point");

endmodule
`default_nettype wire
